@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the Huffman stream decoder core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property held every cycle out of reset
`define HSD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
// Same-cycle implication
`define HSD_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("implication failed");
`else
`define HSD_ASSERT(lbl, clk, rstn, prop)
`define HSD_IMPLY(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ rtl/hsd_pkg.sv @@
// ----------------------------------------------------------------------------
// hsd_pkg
// Types and constants of the Huffman stream decoder.
// ----------------------------------------------------------------------------
`default_nettype none
package hsd_pkg;

  localparam int HDR_BITS   = 3;
  localparam int LEN_BITS   = 12;
  localparam int SYM_BITS   = 8;
  localparam int NODE_IDX_W = 9;
  localparam int ENTRY_W    = 19;
  localparam int LEAF_POS   = 18;
  localparam int RES_W      = 12;

  typedef enum logic [2:0] {
    PH_HDR  = 3'd0,
    PH_LEN  = 3'd1,
    PH_FLAG = 3'd2,
    PH_SYM  = 3'd3,
    PH_WALK = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    ST_SYMBOL   = 3'd0,
    ST_DONE     = 3'd1,
    ST_BAD_TREE = 3'd2,
    ST_TRUNC    = 3'd3,
    ST_NULL     = 3'd4,
    ST_OVERFLOW = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BIT,
    S_WR,
    S_JB,
    S_JC,
    S_FIN,
    S_R1,
    S_R2,
    S_END,
    S_FLUSH
  } state_e;

  typedef struct packed {
    logic [SYM_BITS-1:0] symbol;
    status_e             status;
    logic                eor;
  } res_t;

endpackage
`default_nettype wire

@@ rtl/hsd_fifo.sv @@
// ----------------------------------------------------------------------------
// hsd_fifo
// Small register queue with push/full and pop/empty handshakes.
// ----------------------------------------------------------------------------
`default_nettype none
module hsd_fifo import hsd_pkg::*; #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      data_o,
  output logic                  empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  // pointer and count update
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

@@ rtl/hsd_core.sv @@
// ----------------------------------------------------------------------------
// hsd_core
// Bit-serial back end: rebuilds the tree and walks it, one bit per step.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module hsd_core import hsd_pkg::*; #(
  parameter int MAX_LEAVES = 256,
  parameter int NODE_DEPTH = 512
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [SYM_BITS-1:0] in_byte_i,
  input  wire logic                in_last_i,
  input  wire logic                in_empty_i,
  output logic                     in_pop_o,
  output res_t                     out_data_o,
  input  wire logic                out_full_i,
  output logic                     out_push_o
);

  localparam int SA_W = $clog2(MAX_LEAVES);
  localparam int NA_W = $clog2(NODE_DEPTH);

  // memories
  logic [ENTRY_W-1:0]    node_mem [NODE_DEPTH];
  logic [NODE_IDX_W-1:0] stack_mem [MAX_LEAVES];
  logic [ENTRY_W-1:0]    node_rd_q;
  logic [NODE_IDX_W-1:0] stack_rd_q;
  logic                  node_we, stack_we;
  logic [NA_W-1:0]       node_wa, node_ra;
  logic [SA_W-1:0]       stack_wa, stack_ra;
  logic [ENTRY_W-1:0]    node_wd;
  logic [NODE_IDX_W-1:0] stack_wd;

  // control and tree state
  state_e                state_q, state_d;
  phase_e                phase_q, phase_d;
  logic [3:0]            fc_q, fc_d;
  logic [3:0]            tail_q, tail_d;
  logic [LEN_BITS-1:0]   tbl_q, tbl_d;
  logic [SYM_BITS-1:0]   shift_q, shift_d;
  logic [8:0]            lvl_q, lvl_d;
  logic [9:0]            nodes_q, nodes_d;
  logic                  stop_q, stop_d;
  logic                  errseen_q, errseen_d;
  logic [SYM_BITS-1:0]   byte_q, byte_d;
  logic                  last_q, last_d;
  logic [3:0]            bit_q, bit_d;
  logic [3:0]            limit_q, limit_d;
  status_e               err_q, err_d;
  logic [NODE_IDX_W-1:0] r_q, r_d;
  logic [ENTRY_W-1:0]    root_q, root_d;
  logic [ENTRY_W-1:0]    cur_q, cur_d;
  logic                  pend_v_q, pend_v_d;
  res_t                  pend_q, pend_d;

  logic                  cur_bit;
  logic [NODE_IDX_W-1:0] child;
  logic [SYM_BITS-1:0]   sh_new;
  logic [LEN_BITS-1:0]   tbl_new, tbl_dec;
  logic [3:0]            tail_new;
  logic                  do_restart;
  logic                  emit;
  res_t                  emit_res;
  logic                  emit_ok;

  assign cur_bit  = byte_q[~bit_q[2:0]];
  assign child    = cur_bit ? cur_q[NODE_IDX_W-1:0] : cur_q[2*NODE_IDX_W-1:NODE_IDX_W];
  assign sh_new   = {shift_q[SYM_BITS-2:0], cur_bit};
  assign tbl_new  = tbl_q | (LEN_BITS'(cur_bit) << fc_q);
  assign tbl_dec  = tbl_q - LEN_BITS'(1);
  assign tail_new = (in_byte_i[7:5] == 3'd0) ? 4'd8 : {1'b0, in_byte_i[7:5]};
  // a new result may be taken when the pending slot can move on
  assign emit_ok  = !(pend_v_q && out_full_i);

  // next state and datapath control
  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    fc_d       = fc_q;
    tail_d     = tail_q;
    tbl_d      = tbl_q;
    shift_d    = shift_q;
    lvl_d      = lvl_q;
    nodes_d    = nodes_q;
    stop_d     = stop_q;
    errseen_d  = errseen_q;
    byte_d     = byte_q;
    last_d     = last_q;
    bit_d      = bit_q;
    limit_d    = limit_q;
    err_d      = err_q;
    r_d        = r_q;
    root_d     = root_q;
    cur_d      = cur_q;
    pend_v_d   = pend_v_q;
    pend_d     = pend_q;
    node_we    = 1'b0;
    node_wa    = nodes_q[NA_W-1:0];
    node_wd    = '0;
    node_ra    = '0;
    stack_we   = 1'b0;
    stack_wa   = lvl_q[SA_W-1:0];
    stack_wd   = nodes_q[NODE_IDX_W-1:0];
    stack_ra   = '0;
    in_pop_o   = 1'b0;
    out_push_o = 1'b0;
    out_data_o = pend_q;
    do_restart = 1'b0;
    emit       = 1'b0;
    emit_res   = '{symbol: '0, status: ST_SYMBOL, eor: 1'b0};

    case (state_q)
      S_IDLE: begin
        if (!in_empty_i) begin
          in_pop_o = 1'b1;
          if (errseen_q) begin
            do_restart = in_last_i;
          end else begin
            byte_d  = in_byte_i;
            last_d  = in_last_i;
            bit_d   = '0;
            err_d   = ST_SYMBOL;
            if (phase_q == PH_HDR) begin
              tail_d  = tail_new;
              limit_d = in_last_i ? tail_new : 4'd8;
            end else begin
              limit_d = in_last_i ? tail_q : 4'd8;
            end
            state_d = S_BIT;
          end
        end
      end

      S_BIT: begin
        if (bit_q == limit_q) begin
          state_d = S_END;
        end else begin
          case (phase_q)
            PH_HDR: begin
              bit_d = bit_q + 4'd1;
              fc_d  = fc_q + 4'd1;
              if (fc_q == 4'(HDR_BITS - 1)) begin
                phase_d = PH_LEN;
                fc_d    = '0;
                tbl_d   = '0;
              end
            end
            PH_LEN: begin
              bit_d = bit_q + 4'd1;
              tbl_d = tbl_new;
              fc_d  = fc_q + 4'd1;
              if (fc_q == 4'(LEN_BITS - 1)) begin
                fc_d    = '0;
                phase_d = PH_FLAG;
                if (tbl_new == '0) begin
                  state_d = S_FIN;
                end
              end
            end
            PH_FLAG, PH_SYM: begin
              bit_d   = bit_q + 4'd1;
              tbl_d   = tbl_dec;
              state_d = (tbl_dec == '0) ? S_FIN : S_BIT;
              if (!stop_q) begin
                if (phase_q == PH_FLAG) begin
                  if (cur_bit) begin
                    phase_d = PH_SYM;
                    fc_d    = '0;
                    shift_d = '0;
                  end else if (lvl_q < 9'd2) begin
                    stop_d = 1'b1;
                  end else if (nodes_q >= 10'(NODE_DEPTH)) begin
                    err_d   = ST_OVERFLOW;
                    state_d = S_END;
                  end else begin
                    // join: fetch right child first
                    stack_ra = SA_W'(lvl_q - 9'd1);
                    state_d  = S_JB;
                  end
                end else begin
                  shift_d = sh_new;
                  fc_d    = fc_q + 4'd1;
                  if (fc_q == 4'(SYM_BITS - 1)) begin
                    if (lvl_q >= 9'(MAX_LEAVES) || nodes_q >= 10'(NODE_DEPTH)) begin
                      err_d   = ST_OVERFLOW;
                      state_d = S_END;
                    end else begin
                      // leaf: store node, push its index
                      node_we  = 1'b1;
                      node_wd  = {1'b1, 10'd0, sh_new};
                      stack_we = 1'b1;
                      lvl_d    = lvl_q + 9'd1;
                      nodes_d  = nodes_q + 10'd1;
                      fc_d     = '0;
                      phase_d  = PH_FLAG;
                    end
                  end
                end
              end
            end
            PH_WALK: begin
              if (cur_q[LEAF_POS]) begin
                err_d   = ST_NULL;
                state_d = S_END;
              end else begin
                node_ra = child[NA_W-1:0];
                state_d = S_WR;
              end
            end
            default: begin
              state_d = S_END;
            end
          endcase
        end
      end

      // child entry arrives; keep the read address stable while stalled
      S_WR: begin
        node_ra = child[NA_W-1:0];
        if (node_rd_q[LEAF_POS]) begin
          emit     = 1'b1;
          emit_res = '{symbol: node_rd_q[SYM_BITS-1:0], status: ST_SYMBOL, eor: 1'b0};
          if (emit_ok) begin
            cur_d   = root_q;
            bit_d   = bit_q + 4'd1;
            state_d = S_BIT;
          end
        end else begin
          cur_d   = node_rd_q;
          bit_d   = bit_q + 4'd1;
          state_d = S_BIT;
        end
      end

      S_JB: begin
        r_d      = stack_rd_q;
        stack_ra = SA_W'(lvl_q - 9'd2);
        state_d  = S_JC;
      end

      S_JC: begin
        node_we  = 1'b1;
        node_wd  = {1'b0, stack_rd_q, r_q};
        stack_we = 1'b1;
        stack_wa = SA_W'(lvl_q - 9'd2);
        lvl_d    = lvl_q - 9'd1;
        nodes_d  = nodes_q + 10'd1;
        state_d  = (tbl_q == '0) ? S_FIN : S_BIT;
      end

      // end of tree bits: check, then fetch root
      S_FIN: begin
        if (phase_q == PH_SYM || lvl_q != 9'd1) begin
          err_d   = ST_BAD_TREE;
          state_d = S_END;
        end else begin
          stack_ra = '0;
          state_d  = S_R1;
        end
      end

      S_R1: begin
        node_ra = stack_rd_q[NA_W-1:0];
        state_d = S_R2;
      end

      S_R2: begin
        root_d  = node_rd_q;
        cur_d   = node_rd_q;
        phase_d = PH_WALK;
        state_d = S_BIT;
      end

      S_END: begin
        if (err_q != ST_SYMBOL) begin
          emit     = 1'b1;
          emit_res = '{symbol: '0, status: err_q, eor: 1'b0};
        end else if (last_q) begin
          emit     = 1'b1;
          emit_res = '{symbol: '0, status: (phase_q == PH_WALK) ? ST_DONE : ST_TRUNC,
                       eor: 1'b0};
        end
        if (!emit || emit_ok) begin
          state_d = S_FLUSH;
        end
      end

      // last result of the byte goes out flagged
      S_FLUSH: begin
        if (!pend_v_q || !out_full_i) begin
          if (pend_v_q) begin
            out_push_o     = 1'b1;
            out_data_o.eor = 1'b1;
            pend_v_d       = 1'b0;
          end
          if (err_q != ST_SYMBOL && !last_q) begin
            errseen_d = 1'b1;
          end else if (last_q) begin
            do_restart = 1'b1;
          end
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // new result replaces the pending one, which leaves unflagged
    if (emit && emit_ok) begin
      if (pend_v_q) begin
        out_push_o     = 1'b1;
        out_data_o.eor = 1'b0;
      end
      pend_d   = emit_res;
      pend_v_d = 1'b1;
    end

    if (do_restart) begin
      phase_d   = PH_HDR;
      fc_d      = '0;
      tail_d    = '0;
      tbl_d     = '0;
      shift_d   = '0;
      lvl_d     = '0;
      nodes_d   = '0;
      stop_d    = 1'b0;
      errseen_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      phase_q   <= PH_HDR;
      fc_q      <= '0;
      tail_q    <= '0;
      tbl_q     <= '0;
      shift_q   <= '0;
      lvl_q     <= '0;
      nodes_q   <= '0;
      stop_q    <= 1'b0;
      errseen_q <= 1'b0;
      last_q    <= 1'b0;
      bit_q     <= '0;
      limit_q   <= '0;
      err_q     <= ST_SYMBOL;
      pend_v_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      phase_q   <= phase_d;
      fc_q      <= fc_d;
      tail_q    <= tail_d;
      tbl_q     <= tbl_d;
      shift_q   <= shift_d;
      lvl_q     <= lvl_d;
      nodes_q   <= nodes_d;
      stop_q    <= stop_d;
      errseen_q <= errseen_d;
      last_q    <= last_d;
      bit_q     <= bit_d;
      limit_q   <= limit_d;
      err_q     <= err_d;
      pend_v_q  <= pend_v_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    r_q    <= r_d;
    root_q <= root_d;
    cur_q  <= cur_d;
    pend_q <= pend_d;
  end

  // node store
  always_ff @(posedge clk_i) begin
    if (node_we) begin
      node_mem[node_wa] <= node_wd;
    end
    node_rd_q <= node_mem[node_ra];
  end

  // index stack
  always_ff @(posedge clk_i) begin
    if (stack_we) begin
      stack_mem[stack_wa] <= stack_wd;
    end
    stack_rd_q <= stack_mem[stack_ra];
  end

  `HSD_IMPLY(a_no_push_full, clk_i, rst_ni, out_push_o, !out_full_i)
  `HSD_IMPLY(a_no_pop_empty, clk_i, rst_ni, in_pop_o, !in_empty_i)
  `HSD_ASSERT(a_lvl_bound, clk_i, rst_ni, lvl_q <= 9'(MAX_LEAVES))
  `HSD_IMPLY(a_walk_one_root, clk_i, rst_ni, phase_q == PH_WALK, lvl_q == 9'd1)
  `HSD_IMPLY(a_flush_clears, clk_i, rst_ni, state_q == S_FLUSH && state_d == S_IDLE,
             !pend_v_d)

endmodule
`default_nettype wire

@@ rtl/huffman_stream_decoder_unit.sv @@
// Huffman stream decoder: one file byte in, decoded symbols and status out.
// Each byte is fetched, then decoded bit by bit: a join bit also reads two stack entries,
// a walk bit reads the child node, and closing the tree checks it and fetches the root; the
// byte ends in S_END and S_FLUSH. Result stalls can hold it; bytes after an error are just popped.
// Reset (rst_ni low, asynchronous) empties both queues and returns the
// decoder to the header phase; the node store and stack need no clearing.
`default_nettype none
module huffman_stream_decoder_unit import hsd_pkg::*; #(
  parameter int MAX_LEAVES = 256,
  parameter int NODE_DEPTH = 512
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push,
  output logic                     full,
  input  wire logic [SYM_BITS-1:0] data_byte_i,
  input  wire logic                last_byte_i,
  input  wire logic                pop,
  output logic                     empty,
  output logic [SYM_BITS-1:0]      symbol_o,
  output logic [2:0]               status_o,
  output logic                     end_of_run_o
);

  logic [SYM_BITS:0]    in_q_data;
  logic                 in_empty, in_pop;
  res_t                 core_res;
  logic                 out_full, out_push;
  logic [RES_W-1:0]     out_q_data;
  res_t                 out_res;

  // front: byte queue
  hsd_fifo #(.WIDTH(SYM_BITS + 1), .DEPTH(2)) u_in_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({last_byte_i, data_byte_i}),
    .full_o  (full),
    .pop_i   (in_pop),
    .data_o  (in_q_data),
    .empty_o (in_empty)
  );

  // back: tree build and walk
  hsd_core #(.MAX_LEAVES(MAX_LEAVES), .NODE_DEPTH(NODE_DEPTH)) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_byte_i  (in_q_data[SYM_BITS-1:0]),
    .in_last_i  (in_q_data[SYM_BITS]),
    .in_empty_i (in_empty),
    .in_pop_o   (in_pop),
    .out_data_o (core_res),
    .out_full_i (out_full),
    .out_push_o (out_push)
  );

  // result queue
  hsd_fifo #(.WIDTH(RES_W), .DEPTH(4)) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  (core_res),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (out_q_data),
    .empty_o (empty)
  );

  assign out_res      = res_t'(out_q_data);
  assign symbol_o     = out_res.symbol;
  assign status_o     = out_res.status;
  assign end_of_run_o = out_res.eor;

endmodule
`default_nettype wire

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// Huffman stream decoder testbench
// Builds compressed files from random trees and codes, plus broken and noise
// files. Each byte is pushed into the decoder, and a behavioral decoder
// predicts the symbol and status stream. Results are popped with random
// stalls and compared in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import hsd_pkg::*;

  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       drain;   // hold the sender until all results are in
  } byte_item_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       push = 1'b0;
  logic [7:0] data_byte_i = '0;
  logic       last_byte_i = 1'b0;
  logic       pop = 1'b0;
  wire        full, empty;
  wire  [7:0] symbol_o;
  wire  [2:0] status_o;
  wire        end_of_run_o;

  huffman_stream_decoder_unit dut (
    .clk_i, .rst_ni, .push, .full, .data_byte_i, .last_byte_i,
    .pop, .empty, .symbol_o, .status_o, .end_of_run_o
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  byte_item_t pending_bytes[$];
  res_t       expected_res[$];
  int         mismatches = 0;
  int         bytes_sent = 0;
  bit         rx_hold = 1'b0;
  bit         tx_burst = 1'b0;

  // ---------------------------------------------------------------------------
  // Behavioral decoder state
  // ---------------------------------------------------------------------------
  logic [18:0] m_nodes[512];
  logic [8:0]  m_stack[256];
  phase_e      m_phase;
  int unsigned m_cnt, m_tail, m_tree_left, m_shift, m_level, m_used, m_walk;
  bit          m_stopped, m_err_seen;

  function automatic void dec_restart();
    m_phase = PH_HDR;
    m_cnt = 0; m_tail = 0; m_tree_left = 0; m_shift = 0;
    m_level = 0; m_used = 0; m_walk = 0; m_stopped = 0; m_err_seen = 0;
  endfunction

  function automatic status_e dec_finish_tree();
    if (m_phase == PH_SYM || m_level != 1) return ST_BAD_TREE;
    m_phase = PH_WALK;
    m_walk  = m_stack[0];
    return ST_SYMBOL;
  endfunction

  // One tree bit; ST_SYMBOL means no error
  function automatic status_e dec_tree_bit(bit b);
    m_tree_left = (m_tree_left - 1) & 12'hFFF;
    if (!m_stopped) begin
      if (m_phase == PH_FLAG) begin
        if (b) begin
          m_phase = PH_SYM; m_cnt = 0; m_shift = 0;
        end else if (m_level < 2) begin
          m_stopped = 1;
        end else begin
          if (m_used >= 512) return ST_OVERFLOW;
          m_nodes[m_used] = {1'b0, m_stack[m_level-2], m_stack[m_level-1]};
          m_stack[m_level-2] = m_used[8:0];
          m_level--;
          m_used++;
        end
      end else begin
        m_shift = ((m_shift << 1) | b) & 8'hFF;
        m_cnt++;
        if (m_cnt == 8) begin
          if (m_level >= 256 || m_used >= 512) return ST_OVERFLOW;
          m_nodes[m_used] = {1'b1, 10'd0, m_shift[7:0]};
          m_stack[m_level] = m_used[8:0];
          m_level++;
          m_used++;
          m_cnt = 0;
          m_phase = PH_FLAG;
        end
      end
    end
    if (m_tree_left == 0) return dec_finish_tree();
    return ST_SYMBOL;
  endfunction

  function automatic void add_result(logic [7:0] sym, status_e st);
    res_t r;
    r.symbol = sym; r.status = st; r.eor = 1'b0;
    expected_res = {expected_res, r};
  endfunction

  // Predict all results caused by one accepted byte
  function automatic void decode_byte(logic [7:0] d, logic last);
    int unsigned lim, v, idx;
    int          n0;
    status_e     err;
    logic [18:0] e, ce;
    logic [8:0]  c;
    bit          b;
    err = ST_SYMBOL;
    n0  = expected_res.size();
    if (m_err_seen) begin
      if (last) dec_restart();
      return;
    end
    if (m_phase == PH_HDR) begin
      v = d[7:5];
      m_tail = (v != 0) ? v : 8;
    end
    lim = last ? m_tail : 8;
    if (lim > 8) lim = 8;
    for (idx = 0; idx < lim && err == ST_SYMBOL; idx++) begin
      b = d[7-idx];
      case (m_phase)
        PH_HDR: begin
          m_cnt++;
          if (m_cnt >= 3) begin
            m_phase = PH_LEN; m_cnt = 0; m_tree_left = 0;
          end
        end
        PH_LEN: begin
          m_tree_left = (m_tree_left | (b << m_cnt)) & 12'hFFF;
          m_cnt++;
          if (m_cnt >= 12) begin
            m_cnt = 0;
            m_phase = PH_FLAG;
            if (m_tree_left == 0) err = dec_finish_tree();
          end
        end
        PH_FLAG, PH_SYM: err = dec_tree_bit(b);
        default: begin
          e = m_nodes[m_walk];
          if (e[18]) begin
            err = ST_NULL;
          end else begin
            c  = b ? e[8:0] : e[17:9];
            ce = m_nodes[c];
            if (ce[18]) begin
              add_result(ce[7:0], ST_SYMBOL);
              m_walk = m_stack[0];
            end else begin
              m_walk = c;
            end
          end
        end
      endcase
    end
    if (err != ST_SYMBOL) begin
      add_result(8'd0, err);
      if (last) dec_restart();
      else m_err_seen = 1;
    end else if (last) begin
      add_result(8'd0, (m_phase == PH_WALK) ? ST_DONE : ST_TRUNC);
      dec_restart();
    end
    if (expected_res.size() > n0) expected_res[$].eor = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // File builder
  // ---------------------------------------------------------------------------
  // Kinds of files
  localparam int F_GOOD     = 0;
  localparam int F_TRUNC    = 1;  // last flag placed before the real end
  localparam int F_ZERO_LEN = 2;
  localparam int F_SHORTLEN = 3;  // tree length cut inside a leaf symbol
  localparam int F_SURPLUS  = 4;  // extra join on an empty stack
  localparam int F_NOJOIN   = 5;  // leaves only; many leaves give overflow

  task automatic queue_file(int leaves, int walk_bits, int kind);
    bit          tree[$];
    bit          all[$];
    int          sc, left, tl, total, nbytes, k;
    logic [7:0]  sym, by;
    byte_item_t  it;
    sc = 0;
    left = leaves;
    if (kind == F_SURPLUS) tree = {tree, 1'b0};
    while (left > 0 || (sc > 1 && kind != F_NOJOIN)) begin
      if (left > 0 && (sc < 2 || kind == F_NOJOIN || $urandom_range(0, 1))) begin
        sym = 8'($urandom_range(0, 255));
        tree = {tree, 1'b1};
        for (k = 7; k >= 0; k--) tree = {tree, sym[k]};
        sc++;
        left--;
      end else begin
        tree = {tree, 1'b0};
        sc--;
      end
    end
    tl = tree.size();
    if (kind == F_ZERO_LEN) tl = 0;
    if (kind == F_SHORTLEN) tl = tl - 3;
    total = 3 + 12 + tree.size() + walk_bits;
    for (k = 2; k >= 0; k--) all = {all, 1'(((total % 8) >> k) & 1)};
    for (k = 0; k < 12; k++) all = {all, 1'((tl >> k) & 1)};
    foreach (tree[j]) all = {all, tree[j]};
    for (k = 0; k < walk_bits; k++) all = {all, 1'($urandom_range(0, 1))};
    nbytes = (total + 7) / 8;
    if (kind == F_TRUNC && nbytes > 1) nbytes = $urandom_range(1, nbytes - 1);
    for (k = 0; k < nbytes; k++) begin
      for (int j = 0; j < 8; j++)
        by[7-j] = (k*8 + j < all.size()) ? all[k*8 + j] : 1'($urandom_range(0, 1));
      it.data = by;
      it.last = (k == nbytes - 1);
      it.drain = 1'b0;
      pending_bytes = {pending_bytes, it};
    end
  endtask

  task automatic queue_byte(logic [7:0] d, logic last, logic drain);
    byte_item_t it;
    it.data = d; it.last = last; it.drain = drain;
    pending_bytes = {pending_bytes, it};
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int kind_pick;
    dec_restart();
    // directed: extremes and special cases
    queue_byte(8'hFF, 1'b1, 1'b0);        // single byte file, header 7 bits
    queue_byte(8'h00, 1'b1, 1'b0);        // single byte, header 0 means 8
    queue_byte(8'h00, 1'b0, 1'b0);
    queue_byte(8'h00, 1'b0, 1'b0);
    queue_byte(8'hFF, 1'b1, 1'b0);        // zero length, then ignored tail
    queue_file(2, 6, F_GOOD);
    queue_file(1, 3, F_GOOD);             // leaf root gives null child
    queue_file(3, 0, F_SHORTLEN);         // unfinished leaf symbol
    queue_file(3, 4, F_SURPLUS);          // surplus join stops the build
    queue_file(2, 0, F_NOJOIN);           // two stacked entries: bad tree
    queue_file(4, 10, F_TRUNC);
    queue_byte(8'h00, 1'b0, 1'b1);        // wait for all results
    queue_byte(8'h00, 1'b1, 1'b0);
    // random files, mostly well formed
    while (pending_bytes.size() < 120) begin
      kind_pick = $urandom_range(0, 9);
      if (kind_pick < 6) queue_file($urandom_range(2, 8), $urandom_range(0, 40), F_GOOD);
      else if (kind_pick == 6) queue_file($urandom_range(1, 5), $urandom_range(0, 20),
                                          $urandom_range(1, 5));
      else if (kind_pick == 7) queue_byte(8'($urandom_range(0, 255)),
                                          1'($urandom_range(0, 1)), 1'b0);
      else queue_file($urandom_range(2, 6), $urandom_range(0, 30), F_TRUNC);
      if ($urandom_range(0, 15) == 0) queue_byte(8'h00, 1'b1, 1'b1);
    end
    queue_file(5, 30, F_GOOD);
  end

  // Reset and receiver hold-off
  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (bytes_sent >= 40);
    @(posedge clk_i);
    rx_hold = 1'b1;
    repeat (400) @(posedge clk_i);
    rx_hold = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Driver
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : driver
    int         gap;
    byte_item_t cur;
    bit         need;
    if (rst_ni) begin
      need = 1'b1;
      if (push && !full) begin
        decode_byte(data_byte_i, last_byte_i);
        bytes_sent++;
      end else if (push) begin
        need = 1'b0;
      end
      if (need) begin
        if (gap > 0) begin
          gap--;
          push <= 1'b0;
        end else if (pending_bytes.size() > 0 && pending_bytes[0].drain) begin
          if (expected_res.size() == 0) void'(pending_bytes.pop_front());
          push <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          cur = pending_bytes.pop_front();
          push <= 1'b1;
          data_byte_i <= cur.data;
          last_byte_i <= cur.last;
          if ($urandom_range(0, 19) == 0) tx_burst = !tx_burst;
          gap = tx_burst ? 0 : $urandom_range(0, 4);
        end else begin
          push <= 1'b0;
        end
      end
    end else begin
      gap = 0;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    int   stall;
    res_t want;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (expected_res.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: symbol %0d status %0d eor %0d",
                     symbol_o, status_o, end_of_run_o);
        end else begin
          want = expected_res.pop_front();
          if (symbol_o !== want.symbol || status_o !== want.status ||
              end_of_run_o !== want.eor) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected sym %0d st %0d eor %0d, got sym %0d st %0d eor %0d",
                       want.symbol, want.status, want.eor,
                       symbol_o, status_o, end_of_run_o);
          end
        end
        stall = tx_burst ? 0 : $urandom_range(0, 4);
      end
      if (stall > 0) stall--;
      pop <= !rx_hold && (stall == 0);
    end else begin
      stall = 0;
    end
  end

  // ---------------------------------------------------------------------------
  // End of run
  // ---------------------------------------------------------------------------
  initial begin
    wait (rst_ni);
    wait (pending_bytes.size() == 0 && bytes_sent > 0);
    @(posedge clk_i);
    wait (!push && expected_res.size() == 0);
    repeat (100) @(posedge clk_i);
    if (mismatches == 0 && expected_res.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
`default_nettype wire

@@ huffman_stream_decoder_unit.f @@
+incdir+rtl
rtl/hsd_pkg.sv
rtl/hsd_fifo.sv
rtl/hsd_core.sv
rtl/huffman_stream_decoder_unit.sv
verif/testbench.sv
